/* rtl/statement_bracket_tracker_unit_defines.svh */
// Assertion macros shared by the statement bracket tracker checker.
`ifndef STATEMENT_BRACKET_TRACKER_UNIT_DEFINES_SVH
`define STATEMENT_BRACKET_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBTU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBTU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SBTU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbt_pkg.sv */
// Types and constants for the statement bracket tracker.
`default_nettype none

package sbt_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_NONE  = 2'd0;
    localparam t_kind KIND_BRACE = 2'd1;
    localparam t_kind KIND_PAREN = 2'd2;
    localparam t_kind KIND_ANGLE = 2'd3;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        ST_CONT     = 3'd0,
        ST_NEWLINE  = 3'd1,
        ST_EOI      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        t_status    status;
        logic [5:0] open_depth;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    function automatic t_kind opener_kind(input logic [7:0] c);
        t_kind k;
        k = KIND_NONE;
        if (c == CH_LBRACE) begin
            k = KIND_BRACE;
        end else if (c == CH_LPAREN) begin
            k = KIND_PAREN;
        end else if (c == CH_LANGLE) begin
            k = KIND_ANGLE;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* rtl/sbt_cell.sv */
// One stack cell: holds a bracket kind, shifts down on push and up on pop.
`default_nettype none

module sbt_cell (
    input  wire                  i_clk,
    input  sbt_pkg::t_cell_ctl   i_ctl,
    input  sbt_pkg::t_kind       i_push_kind,
    input  sbt_pkg::t_kind       i_pop_kind,
    output sbt_pkg::t_kind       o_kind
);

    sbt_pkg::t_kind r_kind;
    sbt_pkg::t_kind n_kind;

    always_comb begin
        n_kind = r_kind;
        if (i_ctl.push) begin
            n_kind = i_push_kind;
        end else if (i_ctl.pop) begin
            n_kind = i_pop_kind;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind = r_kind;

endmodule

`default_nettype wire

/* rtl/sbt_out_buf.sv */
// Output register with skid stage for result items.
`default_nettype none

module sbt_out_buf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  sbt_pkg::t_out_item  i_data,
    output logic                o_full,
    output logic                o_valid,
    input  wire                 i_stall,
    output sbt_pkg::t_out_item  o_data
);

    logic               r_out_v;
    logic               r_skid_v;
    sbt_pkg::t_out_item r_out;
    sbt_pkg::t_out_item r_skid;
    logic               w_take;

    assign w_take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // drain skid into output register
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_load) begin
            if (!r_out_v || w_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

/* rtl/statement_bracket_tracker_unit.sv */
// Statement bracket tracker top level: step logic, cell-chain stack, output buffer.
// The result for an accepted input item is registered in the output register, or in its skid stage when that is held.
// Throughput: one item per cycle while o_stall is low; each item does one push or pop on the cell chain,
//   whose top cell alone feeds the step logic, so the next item needs no wait.
// Input stalls only when the output register and its skid stage are both full.
// Reset (i_rst_n low, synchronous) clears depth, escape and started flags and the
//   output buffer; stack cells keep stale kinds, never read below depth.
`default_nettype none

module statement_bracket_tracker_unit #(
    parameter int MAX_NEST = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  sbt_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  wire                 i_stall,
    output sbt_pkg::t_out_item  o_item
);

    localparam int DW = $clog2(MAX_NEST + 1);

    // Statement state
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic          r_esc;
    logic          n_esc;
    logic          r_started;
    logic          n_started;

    // Stack chain: cell 0 is the top of stack
    sbt_pkg::t_kind     w_kind [MAX_NEST];
    sbt_pkg::t_kind     w_new_kind;
    sbt_pkg::t_cell_ctl w_ctl;

    // Step result
    sbt_pkg::t_out_item w_res;
    logic               w_accept;
    logic               w_full;
    logic [DW+5:0]      w_depth_ext;

    assign w_accept = i_valid && !w_full;
    assign o_stall  = w_full;

    // Step logic: decide push/pop, next flags and the result item
    always_comb begin
        sbt_pkg::t_kind k;
        logic [7:0]     c;
        logic           pop;
        logic           clr;
        c          = i_item.in_byte;
        k          = sbt_pkg::KIND_NONE;
        pop        = 1'b0;
        clr        = 1'b0;
        n_depth    = r_depth;
        n_esc      = r_esc;
        n_started  = r_started;
        w_new_kind = sbt_pkg::KIND_NONE;
        w_ctl      = '0;
        w_res      = '0;
        w_res.status = sbt_pkg::ST_CONT;

        if (i_item.end_of_input) begin
            // end of stream: drop any pending escape, report empty or ended
            clr          = 1'b1;
            w_res.status = r_started ? sbt_pkg::ST_EOI : sbt_pkg::ST_EMPTY;
        end else begin
            n_started = 1'b1;
            if (r_esc) begin
                // escaped byte skips bracket checks
                n_esc = 1'b0;
            end else if (r_depth == '0) begin
                k = sbt_pkg::opener_kind(c);
                if (k == sbt_pkg::KIND_NONE && c == sbt_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end
            end else begin
                unique case (w_kind[0])
                    sbt_pkg::KIND_BRACE: begin
                        if (c == sbt_pkg::CH_RBRACE) begin
                            pop = 1'b1;
                        end else begin
                            k = sbt_pkg::opener_kind(c);
                        end
                    end
                    sbt_pkg::KIND_PAREN: begin
                        if (c == sbt_pkg::CH_RPAREN) begin
                            pop = 1'b1;
                        end else if (c == sbt_pkg::CH_LPAREN) begin
                            k = sbt_pkg::KIND_PAREN;
                        end else if (c == sbt_pkg::CH_BSLASH) begin
                            n_esc = 1'b1;
                        end
                    end
                    sbt_pkg::KIND_ANGLE: begin
                        if (c == sbt_pkg::CH_RANGLE) begin
                            pop = 1'b1;
                        end
                    end
                    default: begin
                        // empty kind never sits below the depth
                    end
                endcase
            end

            if (k != sbt_pkg::KIND_NONE && r_depth == DW'(MAX_NEST)) begin
                // push into a full stack: flag overflow, drop the byte
                clr          = 1'b1;
                w_res.status = sbt_pkg::ST_OVERFLOW;
            end else begin
                if (k != sbt_pkg::KIND_NONE) begin
                    w_ctl.push = 1'b1;
                    w_new_kind = k;
                    n_depth    = r_depth + DW'(1);
                end else if (pop) begin
                    w_ctl.pop = 1'b1;
                    n_depth   = r_depth - DW'(1);
                end
                if (c == sbt_pkg::CH_NEWLINE && n_depth == '0) begin
                    // newline at depth zero ends the statement, not forwarded
                    clr          = 1'b1;
                    w_res.status = sbt_pkg::ST_NEWLINE;
                end else begin
                    w_res.out_byte  = c;
                    w_res.out_valid = 1'b1;
                end
            end
        end

        if (clr) begin
            n_depth   = '0;
            n_esc     = 1'b0;
            n_started = 1'b0;
        end

        // report depth only while the statement continues
        w_depth_ext      = {6'd0, clr ? {DW{1'b0}} : n_depth};
        w_res.open_depth = w_depth_ext[5:0];

        // only move the stack for an accepted item
        if (!w_accept) begin
            w_ctl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_esc     <= 1'b0;
            r_started <= 1'b0;
        end else if (w_accept) begin
            r_depth   <= n_depth;
            r_esc     <= n_esc;
            r_started <= n_started;
        end
    end

    // Cell chain: push shifts toward the bottom, pop shifts toward the top
    for (genvar g = 0; g < MAX_NEST; g++) begin : g_cell
        sbt_pkg::t_kind w_push_in;
        sbt_pkg::t_kind w_pop_in;
        if (g == 0) begin : g_top
            assign w_push_in = w_new_kind;
        end else begin : g_mid
            assign w_push_in = w_kind[g-1];
        end
        if (g == MAX_NEST - 1) begin : g_bot
            assign w_pop_in = sbt_pkg::KIND_NONE;
        end else begin : g_nxt
            assign w_pop_in = w_kind[g+1];
        end
        sbt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_push_kind (w_push_in),
            .i_pop_kind  (w_pop_in),
            .o_kind      (w_kind[g])
        );
    end

    sbt_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_item)
    );

endmodule

`default_nettype wire

/* rtl/sbt_checker.sv */
// Port-level checker for the statement bracket tracker, bound to the top level.
`default_nettype none
`include "statement_bracket_tracker_unit_defines.svh"

module sbt_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_valid,
    input wire                 o_stall,
    input sbt_pkg::t_in_item   i_item,
    input wire                 o_valid,
    input wire                 i_stall,
    input sbt_pkg::t_out_item  o_item
);

    logic w_done;
    logic w_done_ok;
    logic w_cont;
    logic w_idle;
    logic w_held;

    assign w_done    = o_valid && o_item.status != sbt_pkg::ST_CONT;
    assign w_done_ok = !o_item.out_valid && o_item.open_depth == 6'd0
                       && o_item.out_byte == 8'd0;
    assign w_cont    = o_valid && o_item.status == sbt_pkg::ST_CONT;
    assign w_idle    = !o_valid && !o_stall;
    assign w_held    = o_valid && i_stall;

    `SBTU_ASSERT_SAME(a_end_no_byte, i_clk, i_rst_n, w_done, w_done_ok, "ended item has data")
    `SBTU_ASSERT_SAME(a_cont_has_byte, i_clk, i_rst_n, w_cont, o_item.out_valid, "byte missing")
    `SBTU_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, w_idle, "not empty after reset")
    `SBTU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_held, o_valid && $stable(o_item), "item changed")

endmodule

bind statement_bracket_tracker_unit sbt_checker u_sbt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the statement bracket tracker: directed and random byte streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEST_LIMIT  = 32;
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_WAIT  = 20;

    // Drive every input to a known value from time zero; reset starts asserted.
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    sbt_pkg::t_in_item  i_item  = '0;
    logic               o_stall;
    logic               o_valid;
    sbt_pkg::t_out_item o_item;

    statement_bracket_tracker_unit #(
        .MAX_NEST(NEST_LIMIT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item (o_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Tracker state mirrored on the testbench side.
    sbt_pkg::t_kind     open_kinds [NEST_LIMIT];
    int unsigned        open_count;
    bit                 escape_armed;
    bit                 statement_open;

    // Results predicted for accepted items, oldest first.
    sbt_pkg::t_out_item predicted_results [$];

    int                 mismatch_count;
    int                 cycle_count;
    bit                 idle_enable;
    int                 stall_left;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void close_statement();
        open_count     = 0;
        escape_armed   = 1'b0;
        statement_open = 1'b0;
    endfunction

    function automatic sbt_pkg::t_kind kind_of_opener(input logic [7:0] c);
        case (c)
            sbt_pkg::CH_LBRACE: return sbt_pkg::KIND_BRACE;
            sbt_pkg::CH_LPAREN: return sbt_pkg::KIND_PAREN;
            sbt_pkg::CH_LANGLE: return sbt_pkg::KIND_ANGLE;
            default:            return sbt_pkg::KIND_NONE;
        endcase
    endfunction

    // Advance the mirrored tracker by one item and return the result it must produce.
    function automatic sbt_pkg::t_out_item track_byte(input sbt_pkg::t_in_item it);
        sbt_pkg::t_out_item res;
        sbt_pkg::t_kind     push_kind;
        logic [7:0]         c;
        res        = '0;
        res.status = sbt_pkg::ST_CONT;
        c          = it.in_byte;
        push_kind  = sbt_pkg::KIND_NONE;

        // End of input: drop any pending escape, report empty if nothing was taken.
        if (it.end_of_input) begin
            res.status = statement_open ? sbt_pkg::ST_EOI : sbt_pkg::ST_EMPTY;
            close_statement();
            return res;
        end
        statement_open = 1'b1;

        if (escape_armed) begin
            // Let the escaped byte skip all bracket checks, but not the newline check.
            escape_armed = 1'b0;
        end else if (open_count == 0) begin
            push_kind = kind_of_opener(c);
            if (push_kind == sbt_pkg::KIND_NONE && c == sbt_pkg::CH_BSLASH) begin
                escape_armed = 1'b1;
            end
        end else begin
            case (open_kinds[open_count - 1])
                sbt_pkg::KIND_BRACE: begin
                    if (c == sbt_pkg::CH_RBRACE) begin
                        open_count--;
                    end else begin
                        push_kind = kind_of_opener(c);
                    end
                end
                sbt_pkg::KIND_PAREN: begin
                    if (c == sbt_pkg::CH_RPAREN) begin
                        open_count--;
                    end else if (c == sbt_pkg::CH_LPAREN) begin
                        push_kind = sbt_pkg::KIND_PAREN;
                    end else if (c == sbt_pkg::CH_BSLASH) begin
                        escape_armed = 1'b1;
                    end
                end
                sbt_pkg::KIND_ANGLE: begin
                    if (c == sbt_pkg::CH_RANGLE) begin
                        open_count--;
                    end
                end
                default: begin
                end
            endcase
        end

        // Flag overflow when a push finds the stack already full.
        if (push_kind != sbt_pkg::KIND_NONE) begin
            if (open_count >= NEST_LIMIT) begin
                close_statement();
                res.status = sbt_pkg::ST_OVERFLOW;
                return res;
            end
            open_kinds[open_count] = push_kind;
            open_count++;
        end

        // Newline at depth zero closes the statement and is not forwarded.
        if (c == sbt_pkg::CH_NEWLINE && open_count == 0) begin
            close_statement();
            res.status = sbt_pkg::ST_NEWLINE;
            return res;
        end

        res.out_byte   = c;
        res.out_valid  = 1'b1;
        res.open_depth = open_count[5:0];
        return res;
    endfunction

    // Offer one item, hold it until taken, then record its predicted result.
    task automatic send_item(input sbt_pkg::t_in_item it);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted_results.push_back(track_byte(it));
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(sbt_pkg::t_in_item'{in_byte: c, end_of_input: 1'b0});
    endtask

    task automatic send_end(input logic [7:0] junk);
        send_item(sbt_pkg::t_in_item'{in_byte: junk, end_of_input: 1'b1});
    endtask

    // Pick the next item: end, opener, closer matching the top, escape, newline or any byte.
    task automatic send_random(input int open_pct, input int close_pct, input int end_pct);
        int             roll;
        int             pick;
        sbt_pkg::t_kind top;
        logic [7:0]     c;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (roll < end_pct) begin
            send_end(8'($urandom_range(0, 255)));
            return;
        end
        if (roll < end_pct + open_pct) begin
            c = (pick < 6) ? sbt_pkg::CH_LPAREN :
                (pick < 9) ? sbt_pkg::CH_LBRACE : sbt_pkg::CH_LANGLE;
        end else if (roll < end_pct + open_pct + close_pct) begin
            top = (open_count != 0) ? open_kinds[open_count - 1]
                                    : sbt_pkg::t_kind'(pick % 3 + 1);
            case (top)
                sbt_pkg::KIND_BRACE: c = sbt_pkg::CH_RBRACE;
                sbt_pkg::KIND_PAREN: c = sbt_pkg::CH_RPAREN;
                default:             c = sbt_pkg::CH_RANGLE;
            endcase
        end else if (roll < end_pct + open_pct + close_pct + 5) begin
            c = sbt_pkg::CH_BSLASH;
        end else if (roll < end_pct + open_pct + close_pct + 11) begin
            c = sbt_pkg::CH_NEWLINE;
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        send_char(c);
    endtask

    // Accept a result whenever valid is up and stall is down; compare with the oldest prediction.
    always @(posedge i_clk) begin
        sbt_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %h", o_item));
            end else begin
                want = predicted_results.pop_front();
                if (o_item.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              o_item.out_byte, want.out_byte));
                end
                if (o_item.out_valid !== want.out_valid) begin
                    report_mismatch($sformatf("out_valid %b, want %b",
                                              o_item.out_valid, want.out_valid));
                end
                if (o_item.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_item.status, want.status));
                end
                if (o_item.open_depth !== want.open_depth) begin
                    report_mismatch($sformatf("open_depth %0d, want %0d",
                                              o_item.open_depth, want.open_depth));
                end
            end
        end
    end

    // Stall the result side in random bursts; hold it open when idling is off.
    always @(posedge i_clk) begin
        if (!idle_enable || !i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else if (!i_stall && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left = $urandom_range(0, 13);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Empty input, end right after reset, extreme byte values, ordinary end.
    task automatic test_empty_and_end();
        send_end(8'h00);
        send_end(8'hFF);
        send_char(8'h00);
        send_char(8'hFF);
        send_end(8'hA5);
    endtask

    // Newline as first byte, escaped newline at depth zero.
    task automatic test_newline_cases();
        send_char(sbt_pkg::CH_NEWLINE);
        send_char(8'h61);
        send_char(sbt_pkg::CH_BSLASH);
        send_char(sbt_pkg::CH_NEWLINE);
    endtask

    // Walk every bracket kind: newline forwarded inside braces, escape inside parens,
    // openers ignored inside parens and angles, escape dropped at end of input.
    task automatic test_nesting_rules();
        logic [7:0] seq [$];
        seq = '{sbt_pkg::CH_LBRACE, sbt_pkg::CH_NEWLINE, sbt_pkg::CH_LPAREN,
                sbt_pkg::CH_BSLASH, sbt_pkg::CH_RPAREN, sbt_pkg::CH_LANGLE,
                sbt_pkg::CH_RPAREN, sbt_pkg::CH_LANGLE, sbt_pkg::CH_LBRACE,
                sbt_pkg::CH_RANGLE, sbt_pkg::CH_RBRACE, sbt_pkg::CH_BSLASH};
        foreach (seq[i]) send_char(seq[i]);
        send_end(8'h5C);
    endtask

    // Fill the stack with parens, push once more, then start over.
    task automatic test_overflow();
        repeat (NEST_LIMIT) send_char(sbt_pkg::CH_LPAREN);
        send_char(sbt_pkg::CH_LPAREN);
        send_char(sbt_pkg::CH_RBRACE);
        send_end(8'h00);
    endtask

    // Mostly well-formed statements; flip idling now and then to leave quiet stretches.
    task automatic test_random_statements();
        for (int n = 0; n < 900; n++) begin
            if (n % 100 == 0) idle_enable = ($urandom_range(0, 3) != 0);
            send_random(25, 20, 3);
        end
        idle_enable = 1'b1;
    endtask

    // Push hard and end rarely so the stack reaches its limit and overflows.
    task automatic test_deep_nesting();
        repeat (250) send_random(70, 10, 1);
    endtask

    // Uniform bytes and frequent ends, no structure.
    task automatic test_noise();
        repeat (100) begin
            if ($urandom_range(0, 7) == 0) begin
                send_end(8'($urandom_range(0, 255)));
            end else begin
                send_char(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Full rate on both sides for the last part of the run.
    task automatic test_back_to_back();
        idle_enable = 1'b0;
        repeat (100) send_random(25, 20, 3);
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        idle_enable    = 1'b1;
        stall_left     = 0;
        close_statement();

        // Hold reset from time zero, then release it once.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_end();
        test_newline_cases();
        test_nesting_rules();
        test_overflow();
        test_random_statements();
        test_deep_nesting();
        test_noise();
        test_back_to_back();

        // Drop valid, drain the outstanding results, then wait out DRAIN_WAIT before the verdict.
        i_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
